// ----- design/mrpt_pkg.sv -----
// Package: shared constants, types and witness table for the primality test unit.
package mrpt_pkg;

    localparam int NUM_WITNESSES_DEF = 12;
    localparam int WORD_WIDTH_DEF    = 64;
    localparam int MAX_WITNESSES     = 12;
    localparam int WIT_IDX_W         = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD3,
        ST_SPLIT,
        ST_BASE,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_POW_NEXT,
        ST_CHECK,
        ST_SQR,
        ST_SQR_CHK,
        ST_DONE
    } mrpt_state_t;

    // Request to the modular multiplier and its completion flag.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mrpt_mul_ctl_t;

    function automatic logic [5:0] witness(input logic [WIT_IDX_W-1:0] idx);
        logic [5:0] w;
        case (idx)
            4'd0:    w = 6'd2;
            4'd1:    w = 6'd3;
            4'd2:    w = 6'd5;
            4'd3:    w = 6'd7;
            4'd4:    w = 6'd11;
            4'd5:    w = 6'd13;
            4'd6:    w = 6'd17;
            4'd7:    w = 6'd19;
            4'd8:    w = 6'd23;
            4'd9:    w = 6'd29;
            4'd10:   w = 6'd31;
            4'd11:   w = 6'd37;
            default: w = 6'd37;
        endcase
        return w;
    endfunction

endpackage

// ----- design/mrpt_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, doubling and adding mod n.
module mrpt_mulmod #(
    parameter int WORD_WIDTH = mrpt_pkg::WORD_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] x,
    input  logic [WORD_WIDTH-1:0] y,
    input  logic [WORD_WIDTH-1:0] n,
    output logic [WORD_WIDTH-1:0] result,
    output mrpt_pkg::mrpt_mul_ctl_t ctl
);
    localparam int CW = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [WORD_WIDTH-1:0] y_reg, y_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [WORD_WIDTH-1:0] dbl, gap;

    // Operands are already reduced below n; add_mod via gap to avoid wrap.
    always_comb begin
        gap       = n - acc_reg;
        dbl       = (acc_reg >= gap) ? acc_reg - gap : acc_reg + acc_reg;
        acc_next  = acc_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            y_next    = y;
            cnt_next  = CW'(WORD_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (y_reg[WORD_WIDTH-1])
                acc_next = (dbl >= n - x) ? dbl - (n - x) : dbl + x;
            else
                acc_next = dbl;
            y_next   = {y_reg[WORD_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign result    = acc_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg != CW'(1) |=> busy_reg) else $error("busy dropped early");
    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> acc_reg < n) else $error("product not reduced");
endmodule

// ----- design/miller_rabin_primality_test_unit.sv -----
// Top level: deterministic Miller-Rabin primality test over a bit-serial modular multiplier.
// Tests one WORD_WIDTH-bit candidate at a time and returns one is_prime bit per transfer.
// A single bit-serial modular multiplier does all the modular products. For each witness
// base, every bit of d costs a step state and a squaring, and a set bit costs a multiply
// as well. Each squaring after a^d mod n is one more product. The bits of d and those
// squarings share the word, so one base needs at most 2*(WORD_WIDTH-1) products.
// Trivial cases (below 4, even) finish without the multiplier; a multiple of 3 is found
// by a bit-serial residue pass over the WORD_WIDTH bits of the candidate.
// The input is not ready while an item is in progress; the result sits in an output
// register until transferred, and a new candidate may be taken in the same cycle.
module miller_rabin_primality_test_unit #(
    parameter int NUM_WITNESSES = mrpt_pkg::NUM_WITNESSES_DEF,
    parameter int WORD_WIDTH    = mrpt_pkg::WORD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_candidate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_prime
);
    localparam int CW = $clog2(WORD_WIDTH + 1);
    localparam logic [mrpt_pkg::WIT_IDX_W-1:0] LAST_WIT =
        mrpt_pkg::WIT_IDX_W'(NUM_WITNESSES - 1);

    mrpt_pkg::mrpt_state_t state_reg, state_next;

    logic [WORD_WIDTH-1:0] n_reg, n_next;
    logic [WORD_WIDTH-1:0] d_reg, d_next;      // exponent d, shifted right in the split until odd
    logic [WORD_WIDTH-1:0] b_reg, b_next;      // base power
    logic [WORD_WIDTH-1:0] x_reg, x_next;      // accumulator
    logic [WORD_WIDTH-1:0] sh_reg, sh_next;    // serial shift for mod-3 pass and exponent bits
    logic [1:0]            r3_reg, r3_next;
    logic [CW-1:0]         s_reg, s_next;      // power of two in n-1
    logic [CW-1:0]         r_reg, r_next;      // squaring count
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [mrpt_pkg::WIT_IDX_W-1:0] k_reg, k_next;
    logic                  mv_reg, mv_next;
    logic                  res_reg, res_next;

    logic                  mul_start;
    logic [WORD_WIDTH-1:0] mul_x, mul_y, mul_res;
    mrpt_pkg::mrpt_mul_ctl_t mul_ctl;

    logic [WORD_WIDTH-1:0] nm1, in_n, a_w;

    assign nm1  = n_reg - WORD_WIDTH'(1);
    assign in_n = s_candidate[WORD_WIDTH-1:0];
    assign a_w  = WORD_WIDTH'(mrpt_pkg::witness(k_reg));

    mrpt_mulmod #(.WORD_WIDTH(WORD_WIDTH)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .x(mul_x), .y(mul_y), .n(n_reg), .result(mul_res), .ctl(mul_ctl)
    );

    // Accept a new candidate when idle and the output slot is free or leaving.
    assign s_ready    = (state_reg == mrpt_pkg::ST_IDLE) && (!mv_reg || m_ready);
    assign m_valid    = mv_reg;
    assign m_is_prime = res_reg;

    always_comb begin
        state_next = state_reg;
        n_next = n_reg; d_next = d_reg; b_next = b_reg; x_next = x_reg;
        sh_next = sh_reg; r3_next = r3_reg; s_next = s_reg; r_next = r_reg;
        cnt_next = cnt_reg; k_next = k_reg;
        mv_next = mv_reg && !m_ready;
        res_next = res_reg;
        mul_start = 1'b0;
        mul_x = x_reg;
        mul_y = b_reg;
        case (state_reg)
            mrpt_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    n_next = in_n;
                    if (in_n < WORD_WIDTH'(4)) begin
                        res_next = (in_n >= WORD_WIDTH'(2));
                        state_next = mrpt_pkg::ST_DONE;
                    end else if (!in_n[0]) begin
                        res_next = 1'b0;
                        state_next = mrpt_pkg::ST_DONE;
                    end else begin
                        sh_next  = in_n;
                        r3_next  = 2'd0;
                        cnt_next = CW'(WORD_WIDTH);
                        state_next = mrpt_pkg::ST_MOD3;
                    end
                end
            end
            mrpt_pkg::ST_MOD3: begin
                // Fold one bit per cycle: r = (2r + bit) mod 3.
                case ({r3_reg, sh_reg[WORD_WIDTH-1]})
                    3'b000:  r3_next = 2'd0;
                    3'b001:  r3_next = 2'd1;
                    3'b010:  r3_next = 2'd2;
                    3'b011:  r3_next = 2'd0;
                    3'b100:  r3_next = 2'd1;
                    3'b101:  r3_next = 2'd2;
                    default: r3_next = 2'd0;
                endcase
                sh_next  = {sh_reg[WORD_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    d_next = nm1;
                    s_next = '0;
                    state_next = mrpt_pkg::ST_SPLIT;
                end
            end
            mrpt_pkg::ST_SPLIT: begin
                if (r3_reg == 2'd0) begin
                    res_next = 1'b0;
                    state_next = mrpt_pkg::ST_DONE;
                end else if (!d_reg[0]) begin
                    d_next = {1'b0, d_reg[WORD_WIDTH-1:1]};
                    s_next = s_reg + CW'(1);
                end else begin
                    k_next = '0;
                    sh_next = d_reg;
                    state_next = mrpt_pkg::ST_BASE;
                end
            end
            mrpt_pkg::ST_BASE: begin
                // Witnesses are all below 38, so reduction of the base is a compare.
                if (n_reg <= a_w) begin
                    res_next = 1'b1;
                    state_next = mrpt_pkg::ST_DONE;
                end else begin
                    b_next  = a_w;
                    x_next  = WORD_WIDTH'(1);
                    sh_next = d_reg;
                    state_next = mrpt_pkg::ST_POW_MUL;
                end
            end
            mrpt_pkg::ST_POW_MUL: begin
                if (!mul_ctl.busy && !mul_ctl.done) begin
                    if (sh_reg == '0) begin
                        state_next = mrpt_pkg::ST_CHECK;
                    end else if (sh_reg[0]) begin
                        mul_start = 1'b1;
                    end else begin
                        state_next = mrpt_pkg::ST_POW_SQR;
                    end
                end else if (mul_ctl.done) begin
                    x_next = mul_res;
                    state_next = mrpt_pkg::ST_POW_SQR;
                end
            end
            mrpt_pkg::ST_POW_SQR: begin
                mul_x = b_reg;
                if (!mul_ctl.busy && !mul_ctl.done) begin
                    mul_start = 1'b1;
                end else if (mul_ctl.done) begin
                    b_next = mul_res;
                    state_next = mrpt_pkg::ST_POW_NEXT;
                end
            end
            mrpt_pkg::ST_POW_NEXT: begin
                sh_next = {1'b0, sh_reg[WORD_WIDTH-1:1]};
                state_next = mrpt_pkg::ST_POW_MUL;
            end
            mrpt_pkg::ST_CHECK: begin
                if (x_reg == WORD_WIDTH'(1) || x_reg == nm1) begin
                    state_next = mrpt_pkg::ST_SQR_CHK;
                    r_next = s_reg;
                    x_next = nm1;
                end else begin
                    r_next = CW'(1);
                    state_next = mrpt_pkg::ST_SQR;
                end
            end
            mrpt_pkg::ST_SQR: begin
                mul_y = x_reg;
                if (r_reg >= s_reg) begin
                    res_next = 1'b0;
                    state_next = mrpt_pkg::ST_DONE;
                end else if (!mul_ctl.busy && !mul_ctl.done) begin
                    mul_start = 1'b1;
                end else if (mul_ctl.done) begin
                    x_next = mul_res;
                    r_next = r_reg + CW'(1);
                    state_next = mrpt_pkg::ST_SQR_CHK;
                end
            end
            mrpt_pkg::ST_SQR_CHK: begin
                if (x_reg == nm1) begin
                    if (k_reg == LAST_WIT) begin
                        res_next = 1'b1;
                        state_next = mrpt_pkg::ST_DONE;
                    end else begin
                        k_next = k_reg + mrpt_pkg::WIT_IDX_W'(1);
                        state_next = mrpt_pkg::ST_BASE;
                    end
                end else begin
                    state_next = mrpt_pkg::ST_SQR;
                end
            end
            mrpt_pkg::ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    state_next = mrpt_pkg::ST_IDLE;
                end
            end
            default: state_next = mrpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrpt_pkg::ST_IDLE;
            mv_reg    <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            s_reg     <= s_next;
        end
        n_reg   <= n_next;
        d_reg   <= d_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        sh_reg  <= sh_next;
        r3_reg  <= r3_next;
        res_reg <= res_next;
    end

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime))
        else $error("result dropped while stalled");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != mrpt_pkg::ST_IDLE |-> !s_ready)
        else $error("input ready while busy");
    a_mul_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_ctl.busy) else $error("multiplier restarted while busy");
endmodule

// ----- test/mrpt_checker.sv -----
// Checker: watches both channels, predicts primality and compares each result.
`timescale 1ns / 1ps

module mrpt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_candidate,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_is_prime,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [63:0] BASES [12] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
                                          64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};

    logic expected_verdicts[$];

    function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y,
                                           input logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return 64'(p % {64'd0, m});
    endfunction

    function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                           input logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic primality(input logic [63:0] n);
        logic [63:0] d, x, nm1;
        int s;
        logic passed;
        if (n < 2) return 1'b0;
        if (n == 2 || n == 3) return 1'b1;
        if (n % 2 == 0 || n % 3 == 0) return 1'b0;
        nm1 = n - 1;
        d = nm1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int k = 0; k < 12; k++) begin
            if (n <= BASES[k]) break;
            x = powmod(BASES[k], d, n);
            if (x == 1 || x == nm1) continue;
            passed = 1'b0;
            for (int r = 1; r < s; r++) begin
                x = mulmod(x, x, n);
                if (x == nm1) begin
                    passed = 1'b1;
                    break;
                end
            end
            if (!passed) return 1'b0;
        end
        return 1'b1;
    endfunction

    assign pending_count = expected_verdicts.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_verdicts.push_back(primality(s_candidate));
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("is_prime: unexpected transfer, actual %0d", m_is_prime);
                    fail_count <= fail_count + 1;
                end else if (expected_verdicts[0] !== m_is_prime) begin
                    $error("is_prime: expected %0d actual %0d",
                           expected_verdicts[0], m_is_prime);
                    fail_count <= fail_count + 1;
                    void'(expected_verdicts.pop_front());
                end else begin
                    void'(expected_verdicts.pop_front());
                end
            end
        end
    end

endmodule

// ----- test/miller_rabin_primality_test_unit_tb.sv -----
// Testbench top: drives candidates, stalls both channels at random and gives the verdict.
`timescale 1ns / 1ps

module miller_rabin_primality_test_unit_tb;

    // Worst item is a full 64-bit prime; the limit allows several times its run.
    localparam int WATCHDOG_LIMIT = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_candidate = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_is_prime;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct = 9;
    int          recv_idle_pct = 55;
    int          quiet_cycles = 0;
    logic [63:0] directed_candidates [$];

    always #2 aclk = ~aclk;

    miller_rabin_primality_test_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_candidate(s_candidate),
        .m_valid(m_valid), .m_ready(m_ready), .m_is_prime(m_is_prime)
    );

    mrpt_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_candidate(s_candidate),
        .m_valid(m_valid), .m_ready(m_ready), .m_is_prime(m_is_prime),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Drop ready at random according to the current receiver idle rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Count cycles with no transfer on either channel; give up at the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one candidate, idling first at random, and hold it until the transfer.
    // Valid is left high on return; the next call or the caller drops it.
    task automatic send_candidate(input logic [63:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_candidate <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Random candidate: mostly small (fast), some full odd, a few sparse wide, a few full.
    function automatic logic [63:0] random_candidate();
        logic [63:0] v;
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            v = 64'($urandom_range(100000));
        else if (pick < 80)
            v = {$urandom, $urandom} | 64'd1;
        else if (pick < 90)
            v = (64'd1 << $urandom_range(63)) + 64'($urandom_range(200));
        else
            v = {$urandom, $urandom};
        return v;
    endfunction

    initial begin
        // Extremes, trivial cases, small primes near the bases, strong pseudoprimes,
        // a large prime and a large semiprime.
        directed_candidates = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd25,
                                64'd37, 64'd41, 64'd2047, 64'd3215031751,
                                64'd3825123056546413051, 64'hFFFF_FFFF_FFFF_FFFF,
                                64'hFFFF_FFFF_FFFF_FFC5, 64'd4294967291 * 64'd4294967279,
                                64'd1000000007, 64'h8000_0000_0000_0000, 64'd561};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_candidates[i]) send_candidate(directed_candidates[i]);

        // Hold off until every outstanding result has been drained.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 9 : 0;
            repeat (27) send_candidate(random_candidate());
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- miller_rabin_primality_test_unit.f -----
design/mrpt_pkg.sv
design/mrpt_mulmod.sv
design/miller_rabin_primality_test_unit.sv
test/mrpt_checker.sv
test/miller_rabin_primality_test_unit_tb.sv
